// File: rtl/id3p_pkg.sv
// ----------------------------------------------------------------------------
// id3p_pkg
// Shared types and codes of the ID3v2 tag stream parser.
// ----------------------------------------------------------------------------
package id3p_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_EXTSZ,
        PH_EXTSKIP,
        PH_FHDR,
        PH_CONTENT
    } t_phase;

    typedef logic [2:0] t_kind;

    localparam t_kind KIND_HDR_OK   = 3'd0;
    localparam t_kind KIND_HDR_REJ  = 3'd1;
    localparam t_kind KIND_FRAME    = 3'd2;
    localparam t_kind KIND_CONTENT  = 3'd3;
    localparam t_kind KIND_PAD_END  = 3'd4;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  major_version;
        logic [7:0]  revision;
        logic [3:0]  header_flags;
        logic [29:0] tag_size;
        logic [31:0] frame_id;
        logic [29:0] frame_size;
        logic [7:0]  content_byte;
        logic        frame_last;
        logic        tag_end;
    } t_result;

endpackage

// File: rtl/id3v2_tag_stream_parser_top.sv
// ----------------------------------------------------------------------------
// id3v2_tag_stream_parser_top
// ID3v2 tag parser: one tag byte per beat in, header / frame / content
// results out through a two-entry output buffer.
// ----------------------------------------------------------------------------
// The parser takes one tag byte every clock cycle while input ready is high and
// answers each byte in the same cycle it is taken: its state (header position,
// decoded sizes, area and content counters) is updated by a single pass of
// logic per byte, and any result is registered into a two-entry output
// buffer. Input ready falls only when both buffer entries hold results that
// the consumer has not yet taken, so the sustained rate is one byte per
// cycle whenever the output side keeps up. A beat with tag_start high
// restarts the parser on that byte. There is no clearing sequence after reset.
module id3v2_tag_stream_parser_top
    import id3p_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_tag_byte,
    input  logic        i_tag_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_major_version,
    output logic [7:0]  o_revision,
    output logic [3:0]  o_header_flags,
    output logic [29:0] o_tag_size,
    output logic [31:0] o_frame_id,
    output logic [29:0] o_frame_size,
    output logic [7:0]  o_content_byte,
    output logic        o_frame_last,
    output logic        o_tag_end
);

    logic    in_beat;
    logic    out_take;
    logic    res_valid;
    t_result res;

    t_result r_out,        n_out;
    logic    r_out_valid,  n_out_valid;
    t_result r_skid,       n_skid;
    logic    r_skid_valid, n_skid_valid;

    assign o_in_ready = !r_skid_valid;
    assign in_beat    = i_in_valid && o_in_ready;
    assign out_take   = r_out_valid && i_out_ready;

    id3p_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (in_beat),
        .i_tag_byte   (i_tag_byte),
        .i_tag_start  (i_tag_start),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // a new result only arrives while the skid entry is empty
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (res_valid) begin
            if (!r_out_valid || out_take) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_major_version = r_out.major_version;
    assign o_revision      = r_out.revision;
    assign o_header_flags  = r_out.header_flags;
    assign o_tag_size      = r_out.tag_size;
    assign o_frame_id      = r_out.frame_id;
    assign o_frame_size    = r_out.frame_size;
    assign o_content_byte  = r_out.content_byte;
    assign o_frame_last    = r_out.frame_last;
    assign o_tag_end       = r_out.tag_end;

endmodule

// File: rtl/id3p_core.sv
// ----------------------------------------------------------------------------
// id3p_core
// Byte-wise parse state: header, extended header, frame headers and content.
// Updates its state on every accepted beat and flags at most one result.
// ----------------------------------------------------------------------------
module id3p_core
    import id3p_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_beat_valid,
    input  logic [7:0]  i_tag_byte,
    input  logic        i_tag_start,
    output logic        o_res_valid,
    output t_result     o_res
);

    localparam logic [7:0]  CHAR_I      = 8'h49;
    localparam logic [7:0]  CHAR_D      = 8'h44;
    localparam logic [7:0]  CHAR_3      = 8'h33;
    localparam logic [7:0]  CHAR_UA     = 8'h41;
    localparam logic [7:0]  CHAR_UZ     = 8'h5A;
    localparam logic [7:0]  CHAR_D0     = 8'h30;
    localparam logic [7:0]  CHAR_D9     = 8'h39;
    localparam logic [3:0]  HDR_VER     = 4'd3;
    localparam logic [3:0]  HDR_REV     = 4'd4;
    localparam logic [3:0]  HDR_FLAGS   = 4'd5;
    localparam logic [3:0]  HDR_SIZE0   = 4'd6;
    localparam logic [3:0]  HDR_LAST    = 4'd9;
    localparam logic [3:0]  EXT_LAST    = 4'd3;
    localparam logic [3:0]  FID_END     = 4'd4;
    localparam logic [3:0]  FSIZE_END   = 4'd8;
    localparam logic [3:0]  FHDR_LAST   = 4'd9;
    localparam logic [29:0] EXT_MIN     = 30'd4;
    localparam logic [30:0] FOOTER_LEN  = 31'd10;

    function automatic logic [29:0] acc7(input logic [29:0] acc, input logic [7:0] b);
        acc7 = {acc[22:0], 7'd0} + {22'd0, b};
    endfunction

    t_phase      r_phase,      n_phase;
    logic [3:0]  r_byte_count, n_byte_count;
    logic [3:0]  r_flags,      n_flags;
    logic [29:0] r_acc,        n_acc;
    logic [29:0] r_area,       n_area;
    logic [29:0] r_skip,       n_skip;
    logic [31:0] r_id,         n_id;
    logic [29:0] r_content,    n_content;
    logic [15:0] r_version,    n_version;

    // state as seen by this beat; a tag start clears everything and selects the header phase first
    t_phase      ph;
    logic [3:0]  c;
    logic [3:0]  flags_e;
    logic [29:0] acc_e, area_e, skip_e, content_e;
    logic [31:0] id_e;
    logic [15:0] ver_e;
    logic [7:0]  b;

    logic        fhdr_first;
    logic [29:0] acc_base, acc_step;
    logic [31:0] id_base;
    logic [29:0] area_dec, skip_dec, content_dec;
    logic [29:0] hdr_area;
    logic [29:0] ext_sz, ext_skip;
    logic [30:0] ext_total;
    logic [29:0] ext_area;
    logic        hdr_reject, id_char, footer;

    assign b         = i_tag_byte;
    assign ph        = i_tag_start ? PH_HDR : r_phase;
    assign c         = i_tag_start ? 4'd0   : r_byte_count;
    assign flags_e   = i_tag_start ? 4'd0   : r_flags;
    assign acc_e     = i_tag_start ? 30'd0  : r_acc;
    assign area_e    = i_tag_start ? 30'd0  : r_area;
    assign skip_e    = i_tag_start ? 30'd0  : r_skip;
    assign content_e = i_tag_start ? 30'd0  : r_content;
    assign id_e      = i_tag_start ? 32'd0  : r_id;
    assign ver_e     = i_tag_start ? 16'd0  : r_version;

    assign footer     = flags_e[0];
    assign fhdr_first = (ph == PH_FHDR) && (c == 4'd0);
    assign acc_base   = fhdr_first ? 30'd0 : acc_e;
    assign id_base    = fhdr_first ? 32'd0 : id_e;
    assign acc_step   = acc7(acc_base, b);

    assign area_dec    = (area_e == 30'd0) ? 30'd0 : area_e - 30'd1;
    assign skip_dec    = skip_e - 30'd1;
    assign content_dec = content_e - 30'd1;

    assign hdr_area = (footer && ({1'b0, acc_step} <= FOOTER_LEN)) ? 30'd0 :
                      footer ? acc_step - FOOTER_LEN[29:0] : acc_step;

    // extended size and footer come off the area in one saturating subtract
    assign ext_sz    = (acc_step < EXT_MIN) ? EXT_MIN : acc_step;
    assign ext_skip  = ext_sz - EXT_MIN;
    assign ext_total = {1'b0, ext_sz} + (footer ? FOOTER_LEN : 31'd0);
    assign ext_area  = ({1'b0, area_e} > ext_total) ?
                       area_e - ext_total[29:0] : 30'd0;

    assign hdr_reject = ((c == 4'd0) && (b != CHAR_I)) ||
                        ((c == 4'd1) && (b != CHAR_D)) ||
                        ((c == 4'd2) && (b != CHAR_3)) ||
                        ((c == HDR_FLAGS) && (b[3:0] != 4'd0));

    assign id_char = ((b >= CHAR_UA) && (b <= CHAR_UZ)) ||
                     ((b >= CHAR_D0) && (b <= CHAR_D9));

    // next state
    always_comb begin
        n_phase      = ph;
        n_byte_count = c;
        n_flags      = flags_e;
        n_acc        = acc_e;
        n_area       = area_e;
        n_skip       = skip_e;
        n_id         = id_e;
        n_content    = content_e;
        n_version    = ver_e;
        unique case (ph)
            PH_HDR: begin
                if (hdr_reject) begin
                    n_phase = PH_IDLE;
                end else begin
                    if (c == HDR_VER) begin
                        n_version = {b, 8'd0};
                    end else if (c == HDR_REV) begin
                        n_version = {ver_e[15:8], b};
                    end else if (c == HDR_FLAGS) begin
                        n_flags = b[7:4];
                    end else if (c >= HDR_SIZE0) begin
                        n_acc = acc_step;
                    end
                    if (c < HDR_LAST) begin
                        n_byte_count = c + 4'd1;
                    end else begin
                        n_acc        = 30'd0;
                        n_byte_count = 4'd0;
                        if (flags_e[2]) begin
                            n_phase = PH_EXTSZ;
                            n_area  = acc_step;
                        end else begin
                            n_area  = hdr_area;
                            n_phase = (hdr_area == 30'd0) ? PH_IDLE : PH_FHDR;
                        end
                    end
                end
            end
            PH_EXTSZ: begin
                n_acc = acc_step;
                if (c < EXT_LAST) begin
                    n_byte_count = c + 4'd1;
                end else begin
                    n_area = ext_area;
                    n_skip = ext_skip;
                    if (ext_skip != 30'd0) begin
                        n_phase = PH_EXTSKIP;
                    end else if (ext_area == 30'd0) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase      = PH_FHDR;
                        n_byte_count = 4'd0;
                    end
                end
            end
            PH_EXTSKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 30'd0) begin
                    if (area_e == 30'd0) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase      = PH_FHDR;
                        n_byte_count = 4'd0;
                    end
                end
            end
            PH_FHDR: begin
                if (fhdr_first && !id_char) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_id   = id_base;
                    n_acc  = acc_base;
                    n_area = area_dec;
                    if (c < FID_END) begin
                        n_id = {id_base[23:0], b};
                    end else if (c < FSIZE_END) begin
                        n_acc = acc_step;
                    end
                    if (c < FHDR_LAST) begin
                        n_byte_count = c + 4'd1;
                    end else begin
                        n_content = acc_base;
                        if (acc_base != 30'd0) begin
                            n_phase = PH_CONTENT;
                        end else if (area_dec == 30'd0) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_byte_count = 4'd0;
                        end
                    end
                end
            end
            PH_CONTENT: begin
                n_area    = area_dec;
                n_content = content_dec;
                if (content_dec == 30'd0) begin
                    if (area_dec == 30'd0) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase      = PH_FHDR;
                        n_byte_count = 4'd0;
                    end
                end
            end
            default: begin
                n_phase = ph;
            end
        endcase
    end

    // result of this beat
    always_comb begin
        o_res       = '0;
        o_res_valid = 1'b0;
        unique case (ph)
            PH_HDR: begin
                if (hdr_reject) begin
                    o_res_valid = i_beat_valid;
                    o_res.kind  = KIND_HDR_REJ;
                end else if (c >= HDR_LAST) begin
                    o_res_valid         = i_beat_valid;
                    o_res.kind          = KIND_HDR_OK;
                    o_res.major_version = ver_e[15:8];
                    o_res.revision      = ver_e[7:0];
                    o_res.header_flags  = flags_e;
                    o_res.tag_size      = acc_step;
                    o_res.tag_end       = !flags_e[2] && (hdr_area == 30'd0);
                end
            end
            PH_EXTSZ: begin
                if ((c >= EXT_LAST) && (ext_skip == 30'd0) && (ext_area == 30'd0)) begin
                    o_res_valid   = i_beat_valid;
                    o_res.kind    = KIND_PAD_END;
                    o_res.tag_end = 1'b1;
                end
            end
            PH_EXTSKIP: begin
                if ((skip_dec == 30'd0) && (area_e == 30'd0)) begin
                    o_res_valid   = i_beat_valid;
                    o_res.kind    = KIND_PAD_END;
                    o_res.tag_end = 1'b1;
                end
            end
            PH_FHDR: begin
                if (fhdr_first && !id_char) begin
                    o_res_valid   = i_beat_valid;
                    o_res.kind    = KIND_PAD_END;
                    o_res.tag_end = 1'b1;
                end else if (c >= FHDR_LAST) begin
                    o_res_valid      = i_beat_valid;
                    o_res.kind       = KIND_FRAME;
                    o_res.frame_id   = id_base;
                    o_res.frame_size = acc_base;
                    o_res.frame_last = (acc_base == 30'd0);
                    o_res.tag_end    = (acc_base == 30'd0) && (area_dec == 30'd0);
                end
            end
            PH_CONTENT: begin
                o_res_valid        = i_beat_valid;
                o_res.kind         = KIND_CONTENT;
                o_res.frame_id     = id_e;
                o_res.frame_size   = acc_e;
                o_res.content_byte = b;
                o_res.frame_last   = (content_dec == 30'd0);
                o_res.tag_end      = (content_dec == 30'd0) && (area_dec == 30'd0);
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_byte_count <= 4'd0;
            r_flags      <= 4'd0;
            r_acc        <= 30'd0;
            r_area       <= 30'd0;
            r_skip       <= 30'd0;
            r_id         <= 32'd0;
            r_content    <= 30'd0;
            r_version    <= 16'd0;
        end else if (i_beat_valid) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_flags      <= n_flags;
            r_acc        <= n_acc;
            r_area       <= n_area;
            r_skip       <= n_skip;
            r_id         <= n_id;
            r_content    <= n_content;
            r_version    <= n_version;
        end
    end

endmodule
